// ===== rtl/pomb_pkg.sv =====
// Package for the pixel opacity mass and bound block.
// Holds field widths, fixed-point constants, status codes, controller states
// and the command and status structs between controller and datapath.
package pomb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ALPHA_W   = 18;
    localparam int TRANS_W   = FRAC_BITS + 1;
    localparam int CB_W      = 32;
    localparam int ECHO_W    = 31;
    localparam int STATUS_W  = 2;

    localparam logic [TRANS_W-1:0] ONE_FX = TRANS_W'(1) << FRAC_BITS;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_COLOR_NEG = 2'd1,
        ST_BAD_ALPHA = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic out_load;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_last;
    } t_dp_stat;

endpackage

// ===== rtl/pomb_in_if.sv =====
// Input channel of the pixel opacity mass and bound block.
// Valid/ready handshake with the per-item payload; depends on pomb_pkg.
interface pomb_in_if;
    import pomb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ALPHA_W-1:0] alpha;
    logic                      has_alpha;
    logic                      side;
    logic                      is_last;
    logic signed [CB_W-1:0]    color_bound;

    modport source (output valid, alpha, has_alpha, side, is_last, color_bound,
                    input ready);
    modport sink   (input valid, alpha, has_alpha, side, is_last, color_bound,
                    output ready);
endinterface

// ===== rtl/pomb_out_if.sv =====
// Result channel of the pixel opacity mass and bound block.
// Valid/ready handshake with the per-pixel result payload; depends on pomb_pkg.
interface pomb_out_if;
    import pomb_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TRANS_W-1:0]  before_mass;
    logic [TRANS_W-1:0]  after_mass;
    logic [TRANS_W-1:0]  termination_bound;
    logic [ECHO_W-1:0]   color_bound_echo;
    logic [ECHO_W-1:0]   rgb_bound;

    modport source (output valid, status, before_mass, after_mass, termination_bound,
                    color_bound_echo, rgb_bound, input ready);
    modport sink   (input valid, status, before_mass, after_mass, termination_bound,
                    color_bound_echo, rgb_bound, output ready);
endinterface

// ===== rtl/pomb_ctrl.sv =====
// Controller state machine of the pixel opacity mass and bound block.
// Sequences load, multiply, sum and result load; owns the result valid flag.
// Depends on pomb_pkg.
module pomb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  pomb_pkg::t_dp_stat i_stat,
    output pomb_pkg::t_ctl_cmd o_cmd
);
    import pomb_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = i_stat.is_last ? S_SUM : S_IDLE;
            end
            S_SUM: begin
                n_state = S_OUT;
            end
            S_OUT: if (out_free) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.sum      = (r_state == S_SUM);
        o_cmd.out_load = (r_state == S_OUT) && out_free;
        o_in_ready     = (r_state == S_IDLE);
        // A new result takes the register; otherwise a transfer empties it.
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result valid rose outside the result load state");

    a_sum_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> $past(r_state == S_MUL))
        else $error("sum state entered without a multiply step");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_out_ready) |=> (r_state == S_OUT))
        else $error("pending result overwritten while stalled");
endmodule

// ===== rtl/pomb_dp.sv =====
// Datapath of the pixel opacity mass and bound block.
// Item register, the transmittance product shared by both sides, mass and bound, and the
// result register. Depends on pomb_pkg.
module pomb_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pomb_pkg::t_ctl_cmd                i_cmd,
    output pomb_pkg::t_dp_stat                o_stat,
    input  logic signed [pomb_pkg::ALPHA_W-1:0] i_alpha,
    input  logic                              i_has_alpha,
    input  logic                              i_side,
    input  logic                              i_is_last,
    input  logic signed [pomb_pkg::CB_W-1:0]  i_color_bound,
    output logic [pomb_pkg::STATUS_W-1:0]     o_status,
    output logic [pomb_pkg::TRANS_W-1:0]      o_before_mass,
    output logic [pomb_pkg::TRANS_W-1:0]      o_after_mass,
    output logic [pomb_pkg::TRANS_W-1:0]      o_termination_bound,
    output logic [pomb_pkg::ECHO_W-1:0]       o_color_bound_echo,
    output logic [pomb_pkg::ECHO_W-1:0]       o_rgb_bound
);
    import pomb_pkg::*;

    localparam int PROD_W = 2 * TRANS_W;
    localparam int RGB_W  = ECHO_W + TRANS_W;

    // Latched item.
    logic signed [ALPHA_W-1:0] r_alpha;
    logic                      r_has;
    logic                      r_side;
    logic                      r_last;
    logic signed [CB_W-1:0]    r_cb;

    // Per-pixel state.
    logic [TRANS_W-1:0] r_btrans;
    logic [TRANS_W-1:0] r_atrans;
    logic               r_bad;

    // Staged result ahead of the final multiply.
    t_status            r_st;
    logic [TRANS_W-1:0] r_bm;
    logic [TRANS_W-1:0] r_am;
    logic [TRANS_W-1:0] r_term;
    logic [ECHO_W-1:0]  r_echo;

    // Result register.
    t_status            r_o_st;
    logic [TRANS_W-1:0] r_o_bm;
    logic [TRANS_W-1:0] r_o_am;
    logic [TRANS_W-1:0] r_o_term;
    logic [ECHO_W-1:0]  r_o_echo;
    logic [ECHO_W-1:0]  r_o_rgb;

    logic               alpha_ok;
    logic [TRANS_W-1:0] keep;
    logic [TRANS_W-1:0] sel_trans;
    logic [PROD_W-1:0]  prod;
    logic [TRANS_W-1:0] n_trans;
    logic [TRANS_W-1:0] bm;
    logic [TRANS_W-1:0] am;
    logic [TRANS_W:0]   mass_sum;
    logic [TRANS_W-1:0] term;
    t_status            st;
    logic [RGB_W-1:0]   rgb_full;

    // An alpha is usable when it is not negative and not above one.
    assign alpha_ok  = !r_alpha[ALPHA_W-1] && (r_alpha[TRANS_W-1:0] <= ONE_FX);
    assign keep      = ONE_FX - r_alpha[TRANS_W-1:0];
    assign sel_trans = r_side ? r_atrans : r_btrans;
    assign prod      = {{TRANS_W{1'b0}}, sel_trans} * {{TRANS_W{1'b0}}, keep};
    assign n_trans   = prod[FRAC_BITS +: TRANS_W];

    assign bm       = ONE_FX - r_btrans;
    assign am       = ONE_FX - r_atrans;
    assign mass_sum = {1'b0, bm} + {1'b0, am};
    assign term     = (mass_sum > {1'b0, ONE_FX}) ? ONE_FX : mass_sum[TRANS_W-1:0];

    always_comb begin
        priority if (r_cb[CB_W-1]) begin
            st = ST_COLOR_NEG;
        end else if (r_bad) begin
            st = ST_BAD_ALPHA;
        end else begin
            st = ST_OK;
        end
    end

    assign rgb_full = {{TRANS_W{1'b0}}, r_echo} * {{ECHO_W{1'b0}}, r_term};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_alpha <= i_alpha;
            r_has   <= i_has_alpha;
            r_side  <= i_side;
            r_last  <= i_is_last;
            r_cb    <= i_color_bound;
        end
        if (i_cmd.sum) begin
            r_st   <= st;
            r_bm   <= (st == ST_OK) ? bm : '0;
            r_am   <= (st == ST_OK) ? am : '0;
            r_term <= (st == ST_OK) ? term : '0;
            r_echo <= (st == ST_OK) ? r_cb[ECHO_W-1:0] : '0;
        end
        if (i_cmd.out_load) begin
            r_o_st   <= r_st;
            r_o_bm   <= r_bm;
            r_o_am   <= r_am;
            r_o_term <= r_term;
            r_o_echo <= r_echo;
            r_o_rgb  <= rgb_full[FRAC_BITS +: ECHO_W];
        end
    end

    // Transmittance and the bad-alpha flag return to reset after every closing item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.sum) begin
            r_btrans <= ONE_FX;
            r_atrans <= ONE_FX;
            r_bad    <= 1'b0;
        end else if (i_cmd.mul && r_has) begin
            if (!alpha_ok) begin
                r_bad <= 1'b1;
            end else if (r_side) begin
                r_atrans <= n_trans;
            end else begin
                r_btrans <= n_trans;
            end
        end
    end

    assign o_stat.is_last      = r_last;
    assign o_status            = r_o_st;
    assign o_before_mass       = r_o_bm;
    assign o_after_mass        = r_o_am;
    assign o_termination_bound = r_o_term;
    assign o_color_bound_echo  = r_o_echo;
    assign o_rgb_bound         = r_o_rgb;

    a_trans_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_btrans <= ONE_FX) && (r_atrans <= ONE_FX))
        else $error("transmittance above one");

    a_clear_after_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sum |=> (r_btrans == ONE_FX) && (r_atrans == ONE_FX) && !r_bad)
        else $error("per-pixel state not cleared after closing item");
endmodule

// ===== rtl/pixel_opacity_mass_bound.sv =====
// Pixel opacity mass and bound: top level joining controller and datapath.
// A closing item passes the multiply, sum and result-load states before its
// result is valid. A non-closing item passes the multiply state only; no new
// item is taken until the controller is back in idle. A closing item waits in
// result load while an earlier result is still stalled in the result register.
// Reset: synchronous active-low; clears transmittances to one, the bad-alpha flag, the state and the result valid flag.
module pixel_opacity_mass_bound (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pomb_in_if.sink           i_px,
    pomb_out_if.source        o_res
);
    import pomb_pkg::*;

    t_ctl_cmd cmd;
    t_dp_stat stat;

    pomb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_px.valid),
        .o_in_ready  (i_px.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pomb_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_alpha             (i_px.alpha),
        .i_has_alpha         (i_px.has_alpha),
        .i_side              (i_px.side),
        .i_is_last           (i_px.is_last),
        .i_color_bound       (i_px.color_bound),
        .o_status            (o_res.status),
        .o_before_mass       (o_res.before_mass),
        .o_after_mass        (o_res.after_mass),
        .o_termination_bound (o_res.termination_bound),
        .o_color_bound_echo  (o_res.color_bound_echo),
        .o_rgb_bound         (o_res.rgb_bound)
    );
endmodule
